/* sv/glpc_pkg.sv */
`default_nettype none
package glpc_pkg;

    localparam int MAX_DIM     = 128;
    localparam int COUNT_WIDTH = 31;
    localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W       = 8;
    localparam int PATH_W      = 31;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch dimensions, clear sweep position
        logic zero;     // empty grid: emit a zero result
        logic run;      // visit one cell
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic zero_dim; // request has a zero dimension
        logic last;     // the cell being visited is the final one
    } t_status;

endpackage
`default_nettype wire

/* sv/grid_lattice_path_counter.sv */
`default_nettype none
// Grid lattice path counter: number of right/down paths across a rows x cols grid.
//
// Request channel: drive i_rows, i_cols and raise start; the request is taken
// at a rising edge with start high and busy low. Dimensions above 128 are
// treated as 128.
// Result channel: o_valid is high for exactly one cycle with o_path_count and
// o_overflow; the receiver cannot stall, so the result must be taken then.
// o_overflow marks that some partial count saturated at 2^31-1.
//
// Timing: a request visits one cell per cycle through a single adder and a
// one-row count memory (one read and one write port). busy stays high until
// the final cell has been written; o_valid rises in the same cycle that busy
// falls, and the next request can be taken in that same cycle.
// A request with a zero dimension does not raise busy: a zero result appears
// on the next cycle.
// Reset (synchronous, active low) returns the controller to idle and drops
// o_valid; the row memory needs no clearing since each entry is written
// before it is read within a request.
module grid_lattice_path_counter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [glpc_pkg::DIM_W-1:0]    i_rows,
    input  wire logic [glpc_pkg::DIM_W-1:0]    i_cols,
    output logic                               o_valid,
    output logic [glpc_pkg::PATH_W-1:0]        o_path_count,
    output logic                               o_overflow
);

    glpc_pkg::t_cmd    w_cmd;
    glpc_pkg::t_status w_status;

    glpc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    glpc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rows       (i_rows),
        .i_cols       (i_cols),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_valid      (o_valid),
        .o_path_count (o_path_count),
        .o_overflow   (o_overflow)
    );

endmodule
`default_nettype wire

/* sv/glpc_ctrl.sv */
`default_nettype none
module glpc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  glpc_pkg::t_status    i_status,
    output glpc_pkg::t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   w_accept;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    always_comb begin
        o_cmd.load = w_accept && !i_status.zero_dim;
        o_cmd.zero = w_accept && i_status.zero_dim;
        o_cmd.run  = (r_state == S_RUN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && !i_status.zero_dim) begin
                        r_state <= S_RUN;
                        r_busy  <= 1'b1;
                    end
                end
                S_RUN: begin
                    if (i_status.last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // final cell leaves the add stage this cycle
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* sv/glpc_dp.sv */
`default_nettype none
module glpc_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [glpc_pkg::DIM_W-1:0]    i_rows,
    input  wire logic [glpc_pkg::DIM_W-1:0]    i_cols,
    input  glpc_pkg::t_cmd                     i_cmd,
    output glpc_pkg::t_status                  o_status,
    output logic                               o_valid,
    output logic [glpc_pkg::PATH_W-1:0]        o_path_count,
    output logic                               o_overflow
);

    localparam int IW = glpc_pkg::IDX_W;
    localparam int CW = glpc_pkg::COUNT_WIDTH;

    logic [CW-1:0] r_mem [glpc_pkg::MAX_DIM];

    logic [IW-1:0] r_nr_last, r_nc_last;
    logic [IW-1:0] r_i, r_j;
    logic [IW-1:0] w_nr_last, w_nc_last;

    logic          r_s1_valid, r_s1_edge, r_s1_last;
    logic [IW-1:0] r_s1_j;
    logic [CW-1:0] r_rdata, r_left;
    logic          r_sat;

    logic          r_out_valid, r_out_ovf;
    logic [glpc_pkg::PATH_W-1:0] r_out_count;

    logic [CW:0]   w_sum;
    logic [CW-1:0] w_val;
    logic          w_sat;

    function automatic logic [IW-1:0] f_last_idx(input logic [glpc_pkg::DIM_W-1:0] v);
        if (32'(v) > 32'(glpc_pkg::MAX_DIM)) begin
            return IW'(glpc_pkg::MAX_DIM - 1);
        end
        return IW'(32'(v) - 32'd1);
    endfunction

    assign w_nr_last = f_last_idx(i_rows);
    assign w_nc_last = f_last_idx(i_cols);

    assign o_status.zero_dim = (i_rows == '0) || (i_cols == '0);
    assign o_status.last     = i_cmd.run && (r_i == r_nr_last) && (r_j == r_nc_last);

    // first row and first column always count one
    always_comb begin
        w_sum = {1'b0, r_rdata} + {1'b0, r_left};
        w_sat = 1'b0;
        if (r_s1_edge) begin
            w_val = glpc_pkg::COUNT_ONE;
        end else if (w_sum > {1'b0, glpc_pkg::COUNT_MAX}) begin
            w_val = glpc_pkg::COUNT_MAX;
            w_sat = 1'b1;
        end else begin
            w_val = w_sum[CW-1:0];
        end
    end

    // sweep position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.load) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.run && !o_status.last) begin
            if (r_j == r_nc_last) begin
                r_j <= '0;
                r_i <= r_i + IW'(1);
            end else begin
                r_j <= r_j + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_nr_last <= w_nr_last;
            r_nc_last <= w_nc_last;
        end
    end

    // row store: read the cell above, write back in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.run) begin
            r_rdata <= r_mem[r_j];
        end
        if (r_s1_valid) begin
            r_mem[r_s1_j] <= w_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.run;
            r_s1_last  <= o_status.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run) begin
            r_s1_j    <= r_j;
            r_s1_edge <= (r_i == '0) || (r_j == '0);
        end
        if (r_s1_valid) begin
            r_left <= w_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_cmd.load) begin
            r_sat <= 1'b0;
        end else if (r_s1_valid && w_sat) begin
            r_sat <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.zero || (r_s1_valid && r_s1_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.zero) begin
            r_out_count <= '0;
            r_out_ovf   <= 1'b0;
        end else if (r_s1_valid && r_s1_last) begin
            r_out_count <= glpc_pkg::PATH_W'(w_val);
            r_out_ovf   <= r_sat || w_sat;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_path_count = r_out_count;
    assign o_overflow   = r_out_ovf;

    a_ovf_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_path_count == glpc_pkg::PATH_W'(glpc_pkg::COUNT_MAX)))
        else $error("overflow flagged without saturated count");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_edge) |-> (r_left != '0))
        else $error("left neighbor count is zero inside the grid");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.run |-> ((r_j <= r_nc_last) && (r_i <= r_nr_last)))
        else $error("sweep position beyond grid");

endmodule
`default_nettype wire
